### design/pffra_pkg.sv
// Shared types, constants and helpers of the priority first-fit resource allocator.
`default_nettype none

package pffra_pkg;

    localparam int NUM_WORKERS = 4;
    localparam int WORKER_W    = 2;
    localparam int UNIT_BITS   = 8;
    localparam int ID_W        = 8;
    localparam int AMOUNT_W    = 8;
    localparam int COUNT_W     = 16;
    localparam int OUTCOME_W   = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    typedef logic [UNIT_BITS-1:0] unit_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_GRANTED     = 3'd0,
        OUT_REJECTED    = 3'd1,
        OUT_FORCED_WAIT = 3'd2,
        OUT_BLOCKED     = 3'd3,
        OUT_RELEASED    = 3'd4
    } outcome_t;

    typedef enum logic {
        OP_ALLOCATE = 1'b0,
        OP_RELEASE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [WORKER_W-1:0] worker;
        unit_t               value;
    } cap_write_t;

    typedef struct packed {
        logic fw;
        logic blk;
    } seen_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : count_t'(v + 1'b1);
    endfunction

endpackage

`default_nettype wire

### design/pffra_cfg.sv
// APB register block holding the worker capacities.
`default_nettype none

module pffra_cfg
    import pffra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output unit_t     [NUM_WORKERS-1:0] cap,
    output cap_write_t                 cap_wr
);

    unit_t [NUM_WORKERS-1:0] cap_reg;
    logic                    wr_en;
    logic [WORKER_W-1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else if (wr_en)
        begin
            cap_reg[reg_idx] <= pwdata[UNIT_BITS-1:0];
        end
    end

    assign prdata        = APB_DATA_W'(cap_reg[reg_idx]);
    assign cap           = cap_reg;
    assign cap_wr.valid  = wr_en;
    assign cap_wr.worker = reg_idx;
    assign cap_wr.value  = pwdata[UNIT_BITS-1:0];

endmodule

`default_nettype wire

### design/pffra_seen_mem.sv
// Synchronous memory of the per-id forced-wait and blocked marks.
`default_nettype none

module pffra_seen_mem
    import pffra_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire seen_t         wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output seen_t              rdata
);

    seen_t mem [DEPTH];
    seen_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/pffra_core.sv
// Allocation engine: sequencer, free-unit registers, counters and bitmap read-modify-write.
`default_nettype none

module pffra_core
    import pffra_pkg::*;
#(
    parameter int ID_SPACE = 256,
    localparam int SLOT_W  = $clog2(ID_SPACE)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  opcode,
    input  wire logic [ID_W-1:0]       request_id,
    input  wire logic [AMOUNT_W-1:0]   amount,
    input  wire logic [WORKER_W-1:0]   release_worker,
    input  wire unit_t [NUM_WORKERS-1:0] cap,
    input  wire cap_write_t            cap_wr,
    output logic                       mem_we,
    output logic      [SLOT_W-1:0]     mem_waddr,
    output seen_t                      mem_wdata,
    output logic                       mem_re,
    output logic      [SLOT_W-1:0]     mem_raddr,
    input  wire seen_t                 mem_rdata,
    output logic                       done,
    output logic      [OUTCOME_W-1:0]  outcome,
    output logic      [WORKER_W-1:0]   granted_worker,
    output count_t                     rejected_total,
    output count_t                     forced_wait_total,
    output count_t                     blocked_total
);

    localparam int REM_W = ID_W + 8;
    localparam logic [REM_W-1:0] SPACE_V = REM_W'(ID_SPACE);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ID_SPACE - 1);

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       clr_addr_reg, clr_addr_next;
    opcode_t                 op_reg;
    logic                    id_nz_reg;
    unit_t                   amount_reg;
    logic [WORKER_W-1:0]     rw_reg;
    logic [SLOT_W-1:0]       slot_reg;
    unit_t [NUM_WORKERS-1:0] free_reg, free_next;
    count_t                  rej_count_reg, rej_count_next;
    count_t                  fw_count_reg, fw_count_next;
    count_t                  blk_count_reg, blk_count_next;
    logic                    done_reg, done_next;
    outcome_t                outcome_reg, outcome_next;
    logic [WORKER_W-1:0]     worker_reg, worker_next;

    logic                    accept;
    logic [REM_W-1:0]        rem;
    logic [SLOT_W-1:0]       slot;
    unit_t                   max_cap;
    logic                    fit_found;
    logic [WORKER_W-1:0]     fit_idx;
    logic                    idle_any;
    logic [UNIT_BITS:0]      rel_sum;
    unit_t                   rel_val;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // The id is reduced to a bitmap slot by restoring subtraction.
    always_comb
    begin
        rem = REM_W'(request_id);
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= (SPACE_V << k))
            begin
                rem = rem - (SPACE_V << k);
            end
        end
        slot = rem[SLOT_W-1:0];
    end

    assign mem_re    = accept;
    assign mem_raddr = slot;

    always_comb
    begin
        max_cap   = '0;
        fit_found = 1'b0;
        fit_idx   = '0;
        idle_any  = 1'b0;
        for (int w = 0; w < NUM_WORKERS; w++)
        begin
            if (cap[w] > max_cap)
            begin
                max_cap = cap[w];
            end
            if (free_reg[w] == cap[w])
            begin
                idle_any = 1'b1;
            end
        end
        for (int w = NUM_WORKERS - 1; w >= 0; w--)
        begin
            if (free_reg[w] >= amount_reg)
            begin
                fit_found = 1'b1;
                fit_idx   = WORKER_W'(w);
            end
        end
    end

    assign rel_sum = {1'b0, free_reg[rw_reg]} + {1'b0, amount_reg};
    assign rel_val = (rel_sum > {1'b0, cap[rw_reg]}) ? cap[rw_reg] : rel_sum[UNIT_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = mem_rdata;
        free_next      = free_reg;
        rej_count_next = rej_count_reg;
        fw_count_next  = fw_count_reg;
        blk_count_next = blk_count_reg;
        done_next      = 1'b0;
        outcome_next   = outcome_reg;
        worker_next    = worker_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (op_reg == OP_RELEASE)
                begin
                    free_next[rw_reg] = rel_val;
                    done_next         = 1'b1;
                    outcome_next      = OUT_RELEASED;
                    worker_next       = rw_reg;
                end
                else if (id_nz_reg)
                begin
                    done_next   = 1'b1;
                    worker_next = '0;
                    if (amount_reg > max_cap)
                    begin
                        rej_count_next = sat_inc(rej_count_reg);
                        outcome_next   = OUT_REJECTED;
                    end
                    else if (fit_found)
                    begin
                        free_next[fit_idx] = free_reg[fit_idx] - amount_reg;
                        outcome_next       = OUT_GRANTED;
                        worker_next        = fit_idx;
                    end
                    else if (idle_any)
                    begin
                        outcome_next = OUT_FORCED_WAIT;
                        if (!mem_rdata.fw)
                        begin
                            mem_we        = 1'b1;
                            mem_wdata.fw  = 1'b1;
                            fw_count_next = sat_inc(fw_count_reg);
                        end
                    end
                    else
                    begin
                        outcome_next = OUT_BLOCKED;
                        if (!mem_rdata.blk)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.blk  = 1'b1;
                            blk_count_next = sat_inc(blk_count_reg);
                        end
                    end
                end
            end
            default:
            begin
                state_next    = ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
        if (cap_wr.valid)
        begin
            free_next[cap_wr.worker] = cap_wr.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            free_reg      <= '0;
            rej_count_reg <= '0;
            fw_count_reg  <= '0;
            blk_count_reg <= '0;
            done_reg      <= 1'b0;
            outcome_reg   <= OUT_GRANTED;
            worker_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            free_reg      <= free_next;
            rej_count_reg <= rej_count_next;
            fw_count_reg  <= fw_count_next;
            blk_count_reg <= blk_count_next;
            done_reg      <= done_next;
            outcome_reg   <= outcome_next;
            worker_reg    <= worker_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode_t'(opcode);
            id_nz_reg  <= (request_id != '0);
            amount_reg <= amount[UNIT_BITS-1:0];
            rw_reg     <= release_worker;
            slot_reg   <= slot;
        end
    end

    assign done              = done_reg;
    assign outcome           = outcome_reg;
    assign granted_worker    = worker_reg;
    assign rejected_total    = rej_count_reg;
    assign forced_wait_total = fw_count_reg;
    assign blocked_total     = blk_count_reg;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_EXEC))
        else $error("Result strobe without a decision cycle before it.");

    a_mem_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("Bitmap memory written while idle.");

    a_zero_id_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_ALLOCATE && !id_nz_reg) |=> !done_reg)
        else $error("Allocate with id zero produced a result.");

    a_blocked_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (blk_count_reg >= $past(blk_count_reg)))
        else $error("Blocked count went down.");
`endif

endmodule

`default_nettype wire

### design/priority_first_fit_resource_allocator_top.sv
// Top level of the priority first-fit resource allocator.
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ---------------------------------------------
//   request   start, busy             opcode, request_id, amount, release_worker
//   result    done (one-cycle pulse)  outcome, granted_worker, rejected_total,
//                                     forced_wait_total, blocked_total
//   config    psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// Start is taken in an idle cycle while the id bitmap memory is read, and the
// following cycle decides, updates the free units and writes the bitmap back,
// with busy high. done pulses for one cycle after that, but not for an allocate
// with id zero. After reset, busy stays high while the bitmap memory is cleared.
// The receiver cannot stall results.
`default_nettype none

module priority_first_fit_resource_allocator_top
    import pffra_pkg::*;
#(
    parameter int ID_SPACE = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  opcode,
    input  wire logic [ID_W-1:0]       request_id,
    input  wire logic [AMOUNT_W-1:0]   amount,
    input  wire logic [WORKER_W-1:0]   release_worker,
    output logic                       done,
    output logic      [OUTCOME_W-1:0]  outcome,
    output logic      [WORKER_W-1:0]   granted_worker,
    output logic      [COUNT_W-1:0]    rejected_total,
    output logic      [COUNT_W-1:0]    forced_wait_total,
    output logic      [COUNT_W-1:0]    blocked_total,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SLOT_W = $clog2(ID_SPACE);

    unit_t [NUM_WORKERS-1:0] cap;
    cap_write_t              cap_wr;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    seen_t                   mem_wdata;
    logic                    mem_re;
    logic [SLOT_W-1:0]       mem_raddr;
    seen_t                   mem_rdata;

    pffra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cap     (cap),
        .cap_wr  (cap_wr)
    );

    pffra_seen_mem #(
        .DEPTH (ID_SPACE)
    ) u_seen_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pffra_core #(
        .ID_SPACE (ID_SPACE)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .request_id        (request_id),
        .amount            (amount),
        .release_worker    (release_worker),
        .cap               (cap),
        .cap_wr            (cap_wr),
        .mem_we            (mem_we),
        .mem_waddr         (mem_waddr),
        .mem_wdata         (mem_wdata),
        .mem_re            (mem_re),
        .mem_raddr         (mem_raddr),
        .mem_rdata         (mem_rdata),
        .done              (done),
        .outcome           (outcome),
        .granted_worker    (granted_worker),
        .rejected_total    (rejected_total),
        .forced_wait_total (forced_wait_total),
        .blocked_total     (blocked_total)
    );

endmodule

`default_nettype wire
